[rtl/core/assert_macros.svh]
// Assertion macros shared by the RTL in this folder.
// No dependencies; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/core/pn3_pkg.sv]
// Types, constants and arithmetic helpers for the 3D noise evaluator.
// No dependencies; used by perlin_noise_3d.
package pn3_pkg;

  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned TABLE_SIZE = 256;
  localparam int unsigned IDX_W      = $clog2(TABLE_SIZE);
  localparam int unsigned NUM_LEVELS = 3;
  localparam int unsigned NUM_BANKS  = 7;  // 1 + 2 + 4 table copies, one level each
  localparam int unsigned OUT_SH     = FRAC_BITS + 1 - 16;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_EVAL  = 1'b1
  } op_e;

  typedef logic [IDX_W-1:0]              idx_t;
  typedef logic [7:0]                    perm_t;
  typedef logic signed [FRAC_BITS+1:0]   frac_t;
  typedef logic signed [39:0]            wide_t;
  typedef logic signed [23:0]            fade_t;
  typedef logic [16:0]                   noise_t;

  typedef struct packed {
    idx_t  lat_idx;
    frac_t frac;
  } split_t;

  localparam wide_t ONE_Q     = 40'sd1 <<< FRAC_BITS;
  localparam wide_t FIFTEEN_Q = ONE_Q * 40'sd15;
  localparam wide_t TEN_Q     = ONE_Q * 40'sd10;
  localparam wide_t TWO_Q     = ONE_Q * 40'sd2;
  localparam noise_t NOISE_MAX = 17'h10000;

  // Lattice index truncated toward zero, fraction carries the coordinate's sign.
  function automatic split_t split_coord(input logic [31:0] raw);
    logic                  neg;
    logic [31:0]           mag;
    logic [31-FRAC_BITS:0] ip;
    logic [FRAC_BITS-1:0]  fm;
    split_t                r;
    neg    = raw[31];
    mag    = neg ? (~raw + 32'd1) : raw;
    ip     = mag[31:FRAC_BITS];
    fm     = mag[FRAC_BITS-1:0];
    r.lat_idx = neg ? idx_t'(-ip) : idx_t'(ip);
    r.frac = neg ? (frac_t'(0) - frac_t'(fm)) : frac_t'(fm);
    return r;
  endfunction

  // (a*b) >> FRAC_BITS, sign-magnitude, round half away from zero.
  function automatic wide_t mul_frac(input wide_t a, input fade_t b);
    logic        neg;
    logic [39:0] ma;
    logic [23:0] mb;
    logic [63:0] p;
    logic [63:0] pr;
    wide_t       r;
    neg = a[39] ^ b[23];
    ma  = a[39] ? 40'(-a) : 40'(a);
    mb  = b[23] ? 24'(-b) : 24'(b);
    p   = 64'(ma) * 64'(mb);
    pr  = p + (64'd1 << (FRAC_BITS - 1));
    r   = wide_t'(pr[FRAC_BITS+39:FRAC_BITS]);
    return neg ? -r : r;
  endfunction

  function automatic wide_t blend(input wide_t a, input wide_t b, input fade_t t);
    return a + mul_frac(b - a, t);
  endfunction

  function automatic wide_t gradient(input logic [3:0] h, input wide_t x, input wide_t y,
                                     input wide_t z);
    wide_t g;
    case (h)
      4'h0:    g =  x + y;
      4'h1:    g = -x + y;
      4'h2:    g =  x - y;
      4'h3:    g = -x - y;
      4'h4:    g =  x + z;
      4'h5:    g = -x + z;
      4'h6:    g =  x - z;
      4'h7:    g = -x - z;
      4'h8:    g =  y + z;
      4'h9:    g = -y + z;
      4'hA:    g =  y - z;
      4'hB:    g = -y - z;
      4'hC:    g =  y + x;
      4'hD:    g = -y + z;
      4'hE:    g =  y - x;
      default: g = -y - z;
    endcase
    return g;
  endfunction

  // (r+1)/2 in Q1.16, saturated.
  function automatic noise_t remap(input wide_t r);
    wide_t  s;
    wide_t  rnd;
    noise_t res;
    s   = r + ONE_Q;
    rnd = s + (40'sd1 <<< (OUT_SH - 1));
    if (s <= 40'sd0) begin
      res = '0;
    end else if (s >= TWO_Q) begin
      res = NOISE_MAX;
    end else begin
      res = noise_t'(rnd >>> OUT_SH);
    end
    return res;
  endfunction

endpackage

[rtl/core/perlin_noise_3d.sv]
// 3D improved gradient noise, one point per cycle, loadable permutation table.
// Depends on pn3_pkg and assert_macros.svh.
//
//  channel | handshake            | word contents
//  --------+----------------------+---------------------------------------------
//  in      | in_valid_i/in_ready_o| operation, table_index, table_value, coords
//  out     | out_valid_o/out_ready_i | noise_value (unsigned Q1.16)
//
// One word enters per cycle while in_ready_o is high; an evaluated point passes
// stages s1-s7, then the output register. Table writes give no word.
// Reset: a fill pass writes identity into every bank; in_ready_o
// stays low until it ends.
// Stalls: the pipeline freezes only when a finished result meets a full,
// untaken output register; bubbles and table writes keep flowing.
`include "assert_macros.svh"

module perlin_noise_3d (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                operation_i,
  input  logic [7:0]          table_index_i,
  input  logic [7:0]          table_value_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [16:0]         noise_value_o
);

  // The hash chain perm(perm(perm(x)+y)+z) is three table levels deep. Each
  // level owns its own copies of the table (1, 2 and 4 banks with two read
  // ports each), so all 14 lookups of a point run in one pass. A table write
  // travels down the pipeline and updates each level when it reaches it, so
  // older points still in flight never see it and newer ones always do.

  logic advance;
  logic in_fire;

  // fill pass after reset: entry i of every bank gets i
  logic            init_q;
  pn3_pkg::idx_t   init_cnt_q;

  // ---------------- table banks ----------------
  pn3_pkg::split_t sp [3];
  pn3_pkg::idx_t   bank_base [pn3_pkg::NUM_BANKS];
  pn3_pkg::idx_t   bank_off  [pn3_pkg::NUM_BANKS];
  pn3_pkg::perm_t  perm_val  [pn3_pkg::NUM_BANKS][2];

  logic            wr_en  [pn3_pkg::NUM_LEVELS];
  pn3_pkg::idx_t   wr_idx [pn3_pkg::NUM_LEVELS];
  pn3_pkg::perm_t  wr_val [pn3_pkg::NUM_LEVELS];

  // ---------------- pipeline stages ----------------
  logic             s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q, s6_v_q, s7_v_q;
  pn3_pkg::op_e     s1_op_q, s2_op_q;
  pn3_pkg::idx_t    s1_tidx_q, s2_tidx_q;
  pn3_pkg::perm_t   s1_tval_q, s2_tval_q;
  pn3_pkg::idx_t    s1_yi_q, s1_zi_q, s2_zi_q;
  pn3_pkg::frac_t   s1_frac_q [3];
  pn3_pkg::frac_t   s2_frac_q [3];
  pn3_pkg::frac_t   s3_frac_q [3];
  pn3_pkg::wide_t   s2_sq_q [3];
  pn3_pkg::wide_t   s2_m1_q [3];
  pn3_pkg::wide_t   s3_cube_q [3];
  pn3_pkg::wide_t   s3_inner_q [3];
  pn3_pkg::fade_t   s4_fade_q [3];
  pn3_pkg::wide_t   s4_grad_q [8];
  pn3_pkg::fade_t   s5_v_fade_q, s5_w_fade_q, s6_w_fade_q;
  pn3_pkg::wide_t   s5_lerp_q [4];
  pn3_pkg::wide_t   s6_lerp_q [2];
  pn3_pkg::wide_t   s7_r_q;

  logic             out_valid_q, out_valid_d;
  pn3_pkg::noise_t  noise_q, noise_d;

  // Freeze only when a result would overwrite an untaken one.
  assign advance    = !(s7_v_q && out_valid_q && !out_ready_i);
  assign in_ready_o = advance && !init_q;
  assign in_fire    = in_valid_i && in_ready_o;

  assign sp[0] = pn3_pkg::split_coord(coord_x_i);
  assign sp[1] = pn3_pkg::split_coord(coord_y_i);
  assign sp[2] = pn3_pkg::split_coord(coord_z_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      init_q     <= 1'b1;
      init_cnt_q <= '0;
    end else if (init_q) begin
      init_cnt_q <= init_cnt_q + pn3_pkg::idx_t'(1);
      if (init_cnt_q == '1) begin
        init_q <= 1'b0;
      end
    end
  end

  // Write port of each level follows the word sitting just before it.
  always_comb begin
    wr_en[0]  = in_fire && (pn3_pkg::op_e'(operation_i) == pn3_pkg::OP_WRITE);
    wr_idx[0] = table_index_i;
    wr_val[0] = table_value_i;
    wr_en[1]  = s1_v_q && (s1_op_q == pn3_pkg::OP_WRITE);
    wr_idx[1] = s1_tidx_q;
    wr_val[1] = s1_tval_q;
    wr_en[2]  = s2_v_q && (s2_op_q == pn3_pkg::OP_WRITE);
    wr_idx[2] = s2_tidx_q;
    wr_val[2] = s2_tval_q;
  end

  for (genvar g = 0; g < pn3_pkg::NUM_BANKS; g++) begin : g_bank
    localparam int unsigned LV = (g == 0) ? 0 : ((g < 3) ? 1 : 2);

    pn3_pkg::perm_t mem_q [pn3_pkg::TABLE_SIZE];
    pn3_pkg::perm_t rd_data_q [2];
    pn3_pkg::idx_t  addr0, addr1;

    // bank 0: x; banks 1-2: perm(x), perm(x+1) offset by y;
    // banks 3-6: the four level-2 hashes offset by z
    if (g == 0) begin : g_l1
      assign bank_base[g] = sp[0].lat_idx;
      assign bank_off[g]  = '0;
    end else if (g < 3) begin : g_l2
      assign bank_base[g] = perm_val[0][g-1];
      assign bank_off[g]  = s1_yi_q;
    end else begin : g_l3
      assign bank_base[g] = perm_val[1 + (g-3)/2][(g-3)%2];
      assign bank_off[g]  = s2_zi_q;
    end

    assign addr0 = bank_base[g] + bank_off[g];
    assign addr1 = addr0 + pn3_pkg::idx_t'(1);

    always_ff @(posedge clk_i) begin
      if (init_q) begin
        mem_q[init_cnt_q] <= pn3_pkg::perm_t'(init_cnt_q);
      end else if (advance && wr_en[LV]) begin
        mem_q[wr_idx[LV]] <= wr_val[LV];
      end
      if (advance) begin
        rd_data_q[0] <= mem_q[addr0];
        rd_data_q[1] <= mem_q[addr1];
      end
    end

    assign perm_val[g][0] = rd_data_q[0];
    assign perm_val[g][1] = rd_data_q[1];
  end

  // ---------------- stage valids ----------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
      s5_v_q <= 1'b0;
      s6_v_q <= 1'b0;
      s7_v_q <= 1'b0;
    end else if (advance) begin
      s1_v_q <= in_fire;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q && (s2_op_q == pn3_pkg::OP_EVAL);  // writes retire here
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      s6_v_q <= s5_v_q;
      s7_v_q <= s6_v_q;
    end
  end

  // ---------------- datapath ----------------
  always_ff @(posedge clk_i) begin
    if (advance) begin
      // s1: split coordinates, level-1 lookup in flight
      s1_op_q   <= pn3_pkg::op_e'(operation_i);
      s1_tidx_q <= table_index_i;
      s1_tval_q <= table_value_i;
      s1_yi_q   <= sp[1].lat_idx;
      s1_zi_q   <= sp[2].lat_idx;
      for (int i = 0; i < 3; i++) begin
        s1_frac_q[i] <= sp[i].frac;
      end

      // s2: fade, first products
      s2_op_q   <= s1_op_q;
      s2_tidx_q <= s1_tidx_q;
      s2_tval_q <= s1_tval_q;
      s2_zi_q   <= s1_zi_q;
      for (int i = 0; i < 3; i++) begin
        s2_frac_q[i] <= s1_frac_q[i];
        s2_sq_q[i]   <= pn3_pkg::mul_frac(pn3_pkg::wide_t'(s1_frac_q[i]),
                                          pn3_pkg::fade_t'(s1_frac_q[i]));
        s2_m1_q[i]   <= pn3_pkg::mul_frac(
                          pn3_pkg::wide_t'(s1_frac_q[i]) * 40'sd6 - pn3_pkg::FIFTEEN_Q,
                          pn3_pkg::fade_t'(s1_frac_q[i]));
      end

      // s3: t^3 and 6t^2-15t+10
      for (int i = 0; i < 3; i++) begin
        s3_frac_q[i]  <= s2_frac_q[i];
        s3_cube_q[i]  <= pn3_pkg::mul_frac(s2_sq_q[i], pn3_pkg::fade_t'(s2_frac_q[i]));
        s3_inner_q[i] <= s2_m1_q[i] + pn3_pkg::TEN_Q;
      end

      // s4: fade results and the eight corner gradients
      for (int i = 0; i < 3; i++) begin
        s4_fade_q[i] <= pn3_pkg::fade_t'(pn3_pkg::mul_frac(s3_cube_q[i],
                                                           pn3_pkg::fade_t'(s3_inner_q[i])));
      end
      for (int k = 0; k < 8; k++) begin
        // corner k = {dx, dy, dz}; its hash sits in bank 3+2dx+dy, port dz
        s4_grad_q[k] <= pn3_pkg::gradient(
          perm_val[3 + 2*(k/4) + ((k/2)%2)][k%2][3:0],
          pn3_pkg::wide_t'(s3_frac_q[0]) - (((k/4) == 1) ? pn3_pkg::ONE_Q : '0),
          pn3_pkg::wide_t'(s3_frac_q[1]) - ((((k/2)%2) == 1) ? pn3_pkg::ONE_Q : '0),
          pn3_pkg::wide_t'(s3_frac_q[2]) - (((k%2) == 1) ? pn3_pkg::ONE_Q : '0));
      end

      // s5: blend along x
      s5_v_fade_q  <= s4_fade_q[1];
      s5_w_fade_q  <= s4_fade_q[2];
      s5_lerp_q[0] <= pn3_pkg::blend(s4_grad_q[0], s4_grad_q[4], s4_fade_q[0]);
      s5_lerp_q[1] <= pn3_pkg::blend(s4_grad_q[2], s4_grad_q[6], s4_fade_q[0]);
      s5_lerp_q[2] <= pn3_pkg::blend(s4_grad_q[1], s4_grad_q[5], s4_fade_q[0]);
      s5_lerp_q[3] <= pn3_pkg::blend(s4_grad_q[3], s4_grad_q[7], s4_fade_q[0]);

      // s6: blend along y
      s6_w_fade_q  <= s5_w_fade_q;
      s6_lerp_q[0] <= pn3_pkg::blend(s5_lerp_q[0], s5_lerp_q[1], s5_v_fade_q);
      s6_lerp_q[1] <= pn3_pkg::blend(s5_lerp_q[2], s5_lerp_q[3], s5_v_fade_q);

      // s7: blend along z
      s7_r_q <= pn3_pkg::blend(s6_lerp_q[0], s6_lerp_q[1], s6_w_fade_q);
    end
  end

  // ---------------- output register ----------------
  always_comb begin
    out_valid_d = out_valid_q;
    noise_d     = noise_q;
    if (advance && s7_v_q) begin
      out_valid_d = 1'b1;
      noise_d     = pn3_pkg::remap(s7_r_q);
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    noise_q <= noise_d;
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

  // ---------------- checks ----------------
  `ASSERT_IMPLIES(a_stall_cause, clk_i, rst_ni, !in_ready_o && !init_q,
                  out_valid_q && !out_ready_i && s7_v_q)
  `ASSERT_IMPLIES(a_init_blocks, clk_i, rst_ni, init_q, !in_ready_o)
  `ASSERT_NEXT(a_result_lands, clk_i, rst_ni, advance && s7_v_q, out_valid_q)
  `ASSERT_NEXT(a_write_retires, clk_i, rst_ni,
               advance && s2_v_q && (s2_op_q == pn3_pkg::OP_WRITE), !s3_v_q)

endmodule

[sim/perlin_noise_3d_chk.sv]
// Scoreboard for perlin_noise_3d: watches both channels, predicts each noise word.
// Depends on pn3_pkg for the operation codes; instantiated by perlin_noise_3d_tb.
module perlin_noise_3d_chk (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic        operation_i,
  input  logic [7:0]  table_index_i,
  input  logic [7:0]  table_value_i,
  input  logic [31:0] coord_x_i,
  input  logic [31:0] coord_y_i,
  input  logic [31:0] coord_z_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  logic [16:0] noise_value_i,
  output int          fail_cnt_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE = 64'sd1 <<< 16;

  logic [7:0]  perm_mirror [256];
  logic [16:0] noise_exp_q [$];
  int          mismatch_cnt;

  // Q16 product, round half away from zero, magnitude clamped at 2^62.
  function automatic longint qmul(longint a, longint b);
    logic                 neg;
    longint unsigned      ma, mb;
    logic [127:0]         p;
    neg = (a < 0) != (b < 0);
    ma  = (a < 0) ? -a : a;
    mb  = (b < 0) ? -b : b;
    p   = ({64'd0, ma} * {64'd0, mb} + 128'd32768) >> 16;
    if (p > (128'd1 << 62)) p = 128'd1 << 62;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint fade(longint t);
    longint inner, t3;
    inner = qmul(6 * t - 15 * ONE, t) + 10 * ONE;
    t3    = qmul(qmul(t, t), t);
    return qmul(t3, inner);
  endfunction

  function automatic longint lerp(longint a, longint b, longint t);
    return a + qmul(b - a, t);
  endfunction

  function automatic longint grad(logic [7:0] h, longint x, longint y, longint z);
    case (h[3:0])
      4'h0: return x + y;
      4'h1: return -x + y;
      4'h2: return x - y;
      4'h3: return -x - y;
      4'h4: return x + z;
      4'h5: return -x + z;
      4'h6: return x - z;
      4'h7: return -x - z;
      4'h8: return y + z;
      4'h9: return -y + z;
      4'hA: return y - z;
      4'hB: return -y - z;
      4'hC: return y + x;
      4'hD: return -y + z;
      4'hE: return y - x;
      default: return -y - z;
    endcase
  endfunction

  function automatic logic [7:0] hash3(int x, int y, int z);
    logic [7:0] h;
    h = perm_mirror[x % 256];
    h = perm_mirror[(h + y) % 256];
    return perm_mirror[(h + z) % 256];
  endfunction

  // Lattice index truncated toward zero (mod 256); fraction keeps the sign.
  function automatic void cut(logic [31:0] raw, output int lat_idx, output longint frac);
    logic [31:0] mag;
    logic [15:0] ip;
    mag  = raw[31] ? (~raw + 32'd1) : raw;
    ip   = mag[31:16];
    lat_idx = raw[31] ? int'(8'(-ip)) : int'(ip[7:0]);
    frac = raw[31] ? -longint'(mag[15:0]) : longint'(mag[15:0]);
  endfunction

  function automatic logic [16:0] noise_at(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    int     xi, yi, zi;
    longint xf, yf, zf, u, v, w, a, b, lo, hi, s;
    cut(cx, xi, xf);
    cut(cy, yi, yf);
    cut(cz, zi, zf);
    u  = fade(xf);
    v  = fade(yf);
    w  = fade(zf);
    a  = lerp(grad(hash3(xi, yi, zi), xf, yf, zf),
              grad(hash3(xi + 1, yi, zi), xf - ONE, yf, zf), u);
    b  = lerp(grad(hash3(xi, yi + 1, zi), xf, yf - ONE, zf),
              grad(hash3(xi + 1, yi + 1, zi), xf - ONE, yf - ONE, zf), u);
    lo = lerp(a, b, v);
    a  = lerp(grad(hash3(xi, yi, zi + 1), xf, yf, zf - ONE),
              grad(hash3(xi + 1, yi, zi + 1), xf - ONE, yf, zf - ONE), u);
    b  = lerp(grad(hash3(xi, yi + 1, zi + 1), xf, yf - ONE, zf - ONE),
              grad(hash3(xi + 1, yi + 1, zi + 1), xf - ONE, yf - ONE, zf - ONE), u);
    hi = lerp(a, b, v);
    s  = lerp(lo, hi, w) + ONE;
    if (s <= 0) return 17'd0;
    if (s >= 2 * ONE) return 17'h10000;
    return 17'((s + 1) >>> 1);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    logic [16:0] want;
    if (!rst_ni) begin
      for (int i = 0; i < 256; i++) perm_mirror[i] = 8'(i);
      noise_exp_q.delete();
      mismatch_cnt = 0;
      fail_cnt_o   = 0;
    end else begin
      if (in_valid_i && in_ready_i) begin
        if (operation_i == pn3_pkg::OP_WRITE) perm_mirror[table_index_i] = table_value_i;
        else noise_exp_q.push_back(noise_at(coord_x_i, coord_y_i, coord_z_i));
      end
      if (out_valid_i && out_ready_i) begin
        if (noise_exp_q.size() == 0) begin
          fail_cnt_o++;
          if (mismatch_cnt++ < 10)
            $display("%0t: unexpected noise word %h", $time, noise_value_i);
        end else begin
          want = noise_exp_q.pop_front();
          if (noise_value_i !== want) begin
            fail_cnt_o++;
            if (mismatch_cnt++ < 10)
              $display("%0t: noise_value exp %h got %h", $time, want, noise_value_i);
          end
        end
      end
    end
    pending_o = noise_exp_q.size();
  end
endmodule

[sim/perlin_noise_3d_tb.sv]
// Top of the perlin_noise_3d bench: clock, reset, word stimulus, stalls, verdict.
// Depends on pn3_pkg, perlin_noise_3d and perlin_noise_3d_chk.
module perlin_noise_3d_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;  // cycles with no handshake before giving up

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = pn3_pkg::OP_EVAL;
  logic [7:0]  tbl_idx = '0;
  logic [7:0]  tbl_val = '0;
  logic [31:0] cx = '0, cy = '0, cz = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [16:0] noise;
  int          fail_cnt, pending;
  logic        calm = 1'b0;   // no idling on either side while set
  int          n_writes = 0, n_evals = 0, quiet = 0;

  always #5 clk = ~clk;

  perlin_noise_3d u_top (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .operation_i(op), .table_index_i(tbl_idx), .table_value_i(tbl_val),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .noise_value_o(noise)
  );

  perlin_noise_3d_chk u_chk (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_ready_i(in_ready),
    .operation_i(op), .table_index_i(tbl_idx), .table_value_i(tbl_val),
    .coord_x_i(cx), .coord_y_i(cy), .coord_z_i(cz),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .noise_value_i(noise),
    .fail_cnt_o(fail_cnt), .pending_o(pending)
  );

  // Sink side: ~10% stalls unless in a calm stretch.
  always @(posedge clk) out_ready <= calm || ($urandom_range(99) >= 10);

  // Watchdog on handshake progress.
  always @(posedge clk) begin
    if (rst_n && !((in_valid && in_ready) || (out_valid && out_ready))) quiet <= quiet + 1;
    else quiet <= 0;
    if (quiet >= IDLE_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Present one word, optionally after an idle gap; returns on the accepting edge.
  task automatic put_word(logic o, logic [7:0] idx, logic [7:0] val,
                          logic [31:0] x, logic [31:0] y, logic [31:0] z);
    int gap;
    gap = (!calm && $urandom_range(99) < 10) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o; tbl_idx <= idx; tbl_val <= val;
    cx <= x; cy <= y; cz <= z;
    do @(posedge clk); while (!in_ready);
    if (o == pn3_pkg::OP_WRITE) n_writes++;
    else n_evals++;
  endtask

  task automatic eval_at(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    put_word(pn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom), x, y, z);
  endtask

  // Random coordinate: mostly near the origin, sometimes anywhere in 32 bits.
  function automatic logic [31:0] any_coord();
    if ($urandom_range(3) == 0) return $urandom;
    return 32'($signed($urandom_range(0, 32'h00100000)) - 32'sh00080000);
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: identity table first, then extremes of each field.
    eval_at(32'h0, 32'h0, 32'h0);
    eval_at(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    eval_at(32'h80000000, 32'h80000000, 32'h80000000);  // most negative, exact magnitude
    eval_at(32'hFFFFFFFF, 32'h00000001, 32'hFFFF8000);  // tiny x/y fractions, both signs
    eval_at(32'h00FF8000, 32'h00FFFFFF, 32'h01000000);  // index 255 wraps to 0
    eval_at(32'hFF00C000, 32'hFFFF0000, 32'h00010000);  // whole y and z units, negative x
    eval_at(32'h00008000, 32'hFFFF8000, 32'h00004000);
    put_word(pn3_pkg::OP_WRITE, 8'd0, 8'd255, 0, 0, 0);
    put_word(pn3_pkg::OP_WRITE, 8'd255, 8'd0, 0, 0, 0);
    put_word(pn3_pkg::OP_WRITE, 8'd1, 8'd15, 0, 0, 0);
    eval_at(32'h0000C000, 32'h00004000, 32'hFFFFC000);  // reads fresh writes at once
    eval_at(32'h00FFC000, 32'h00FF4000, 32'h00FF8000);
    // Hash low nibble sweeps all 16 gradient cases.
    for (int h = 0; h < 16; h++) begin
      put_word(pn3_pkg::OP_WRITE, 8'd2, 8'(h * 17), 0, 0, 0);
      eval_at(32'h0002_0000 + 32'(h * 4099), 32'h0000_3000, 32'hFFFF_A000);
    end

    // Random part: writes into the table mixed with evaluations.
    for (int i = 0; i < 1650; i++) begin
      calm <= (i >= 600 && i < 800);
      if ($urandom_range(99) < 15)
        put_word(pn3_pkg::OP_WRITE, 8'($urandom), 8'($urandom), $urandom, $urandom,
                 $urandom);
      else
        put_word(pn3_pkg::OP_EVAL, 8'($urandom), 8'($urandom), any_coord(), any_coord(),
                 any_coord());
    end
    in_valid <= 1'b0;
    calm     <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d table writes and %0d noise evaluations with random stalls.",
             n_writes, n_evals);
    if (fail_cnt == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d failures, %0d words still expected", fail_cnt, pending);
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
